### hdl/rbt_pkg.sv
`default_nettype none

package rbt_pkg;

  localparam int TIME_W  = 32;
  localparam int JOB_W   = 32;
  localparam int BASE_W  = 16;
  localparam int MAXD_W  = 20;
  localparam int DBL_W   = 4;
  localparam int ACT_W   = 2;
  localparam int CFGI_W  = 2;
  localparam int CFGD_W  = 20;
  localparam int SHIFT_W = BASE_W + (1 << DBL_W) - 1;

  localparam logic [ACT_W-1:0] ACT_SET   = 2'd0;
  localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd1;
  localparam logic [ACT_W-1:0] ACT_QUERY = 2'd2;

  localparam logic [CFGI_W-1:0] CFG_BASE_DELAY    = 2'd0;
  localparam logic [CFGI_W-1:0] CFG_MAX_DELAY     = 2'd1;
  localparam logic [CFGI_W-1:0] CFG_MAX_DOUBLINGS = 2'd2;

  localparam logic [BASE_W-1:0] BASE_DELAY_RST    = 16'd5000;
  localparam logic [MAXD_W-1:0] MAX_DELAY_RST     = 20'd60000;
  localparam logic [DBL_W-1:0]  MAX_DOUBLINGS_RST = 4'd4;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_TAIL,
    ST_FINISH
  } rbt_state_t;

  typedef struct packed {
    logic load;
    logic scan;
    logic finish;
  } rbt_cmd_t;

  typedef struct packed {
    logic scan_last;
  } rbt_stat_t;

  // a is earlier than b when a - b is negative as a signed 32-bit value
  function automatic logic wrap_before(input logic [TIME_W-1:0] a,
                                       input logic [TIME_W-1:0] b);
    logic [TIME_W-1:0] d;
    d = a - b;
    return d[TIME_W-1];
  endfunction

endpackage

`default_nettype wire

### hdl/rbt_ctrl.sv
`default_nettype none

module rbt_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  output logic                   out_valid,
  input  wire logic              out_stall,
  input  wire rbt_pkg::rbt_stat_t stat,
  output rbt_pkg::rbt_cmd_t      cmd
);
  import rbt_pkg::*;

  rbt_state_t state, state_next;
  logic       out_free;

  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.finish) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (stat.scan_last) state_next = ST_TAIL;
      end
      ST_TAIL: begin
        state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall   = 1'b1;
    cmd.load   = 1'b0;
    cmd.scan   = 1'b0;
    cmd.finish = 1'b0;
    case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
      end
      ST_TAIL: begin
      end
      ST_FINISH: begin
        cmd.finish = out_free;
      end
      default: begin
      end
    endcase
  end

  a_accept_starts_scan: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (state == ST_SCAN))
    else $error("accepted item did not start a scan");

  a_finish_gives_result: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FINISH && out_free) |=> out_valid)
    else $error("finished item produced no result");

  a_result_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == ST_FINISH))
    else $error("result appeared outside finish");

  a_scan_ends_in_tail: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN && stat.scan_last) |=> (state == ST_TAIL))
    else $error("scan overran the table");

endmodule

`default_nettype wire

### hdl/rbt_datapath.sv
`default_nettype none

module rbt_datapath #(
  parameter int ENTRIES = 8
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire rbt_pkg::rbt_cmd_t            cmd,
  output rbt_pkg::rbt_stat_t                stat,
  input  wire logic                         cfg_we,
  input  wire logic [rbt_pkg::CFGI_W-1:0]   cfg_index,
  input  wire logic [rbt_pkg::CFGD_W-1:0]   cfg_data,
  input  wire logic [rbt_pkg::ACT_W-1:0]    action,
  input  wire logic [rbt_pkg::JOB_W-1:0]    job_id,
  input  wire logic [rbt_pkg::DBL_W-1:0]    retries,
  input  wire logic [rbt_pkg::TIME_W-1:0]   now_time,
  output logic                              due,
  output logic                              hit,
  output logic                              evicted
);
  import rbt_pkg::*;

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

  // configuration
  logic [BASE_W-1:0] base_delay;
  logic [MAXD_W-1:0] max_delay;
  logic [DBL_W-1:0]  max_doublings;

  // item registers
  logic [ACT_W-1:0]  act_q;
  logic [JOB_W-1:0]  job_q;
  logic [TIME_W-1:0] now_q;
  logic [MAXD_W-1:0] delay_q;
  logic [TIME_W-1:0] deadline;

  // table
  logic [JOB_W-1:0]  job_mem [ENTRIES];
  logic [TIME_W-1:0] dl_mem  [ENTRIES];
  logic [ENTRIES-1:0] valid;

  // scan
  logic [IDX_W-1:0]  scan_addr;
  logic              rd_live;
  logic [IDX_W-1:0]  rd_idx;
  logic [JOB_W-1:0]  rd_job;
  logic [TIME_W-1:0] rd_dl;
  logic              rd_vld;
  logic [JOB_W-1:0]  ent_job;
  logic [TIME_W-1:0] ent_dl;
  logic              match;

  // scan results
  logic              found;
  logic [IDX_W-1:0]  found_idx;
  logic [TIME_W-1:0] found_dl;
  logic              empty_found;
  logic [IDX_W-1:0]  empty_idx;
  logic [IDX_W-1:0]  min_idx;
  logic [TIME_W-1:0] min_dl;

  logic [DBL_W-1:0]   shift_amt;
  logic [SHIFT_W-1:0] shifted;
  logic [MAXD_W-1:0]  delay_calc;
  logic               job_nz;
  logic               do_set;
  logic [IDX_W-1:0]   set_slot;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_delay    <= BASE_DELAY_RST;
      max_delay     <= MAX_DELAY_RST;
      max_doublings <= MAX_DOUBLINGS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_BASE_DELAY:    base_delay    <= cfg_data[BASE_W-1:0];
        CFG_MAX_DELAY:     max_delay     <= cfg_data[MAXD_W-1:0];
        CFG_MAX_DOUBLINGS: max_doublings <= cfg_data[DBL_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    shift_amt = (retries > max_doublings) ? max_doublings : retries;
    shifted   = SHIFT_W'(base_delay) << shift_amt;
    if (shifted > SHIFT_W'(max_delay)) begin
      delay_calc = max_delay;
    end else begin
      delay_calc = shifted[MAXD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_q   <= action;
      job_q   <= job_id;
      now_q   <= now_time;
      delay_q <= delay_calc;
    end
    if (cmd.scan) begin
      deadline <= now_q + TIME_W'(delay_q);
    end
  end

  assign job_nz = (job_q != '0);

  // scan address and read pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_addr <= '0;
      rd_live   <= 1'b0;
    end else begin
      rd_live <= cmd.scan;
      if (cmd.load) begin
        scan_addr <= '0;
      end else if (cmd.scan) begin
        scan_addr <= scan_addr + 1'b1;
      end
    end
  end

  assign stat.scan_last = (scan_addr == LAST_IDX);

  assign ent_job = rd_vld ? rd_job : '0;
  assign ent_dl  = rd_vld ? rd_dl : '0;
  assign match   = rd_live && job_nz && (ent_job == job_q);

  always_comb begin
    if (found) begin
      set_slot = found_idx;
    end else if (empty_found) begin
      set_slot = empty_idx;
    end else begin
      set_slot = min_idx;
    end
  end

  assign do_set = cmd.finish && (act_q == ACT_SET) && job_nz;

  always_ff @(posedge clk) begin
    if (cmd.scan) begin
      rd_idx <= scan_addr;
      rd_job <= job_mem[scan_addr];
      rd_dl  <= dl_mem[scan_addr];
      rd_vld <= valid[scan_addr];
    end
    if (do_set) begin
      job_mem[set_slot] <= job_q;
      dl_mem[set_slot]  <= deadline;
    end
  end

  // invalid entries read as empty with deadline zero
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      if (match && (act_q == ACT_CLEAR)) begin
        valid[rd_idx] <= 1'b0;
      end
      if (do_set) begin
        valid[set_slot] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      found       <= 1'b0;
      empty_found <= 1'b0;
    end else if (rd_live) begin
      if (match && !found) begin
        found     <= 1'b1;
        found_idx <= rd_idx;
        found_dl  <= ent_dl;
      end
      if ((ent_job == '0) && !empty_found) begin
        empty_found <= 1'b1;
        empty_idx   <= rd_idx;
      end
      // soonest deadline, first slot wins ties
      if ((rd_idx == '0) || wrap_before(ent_dl, min_dl)) begin
        min_idx <= rd_idx;
        min_dl  <= ent_dl;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      due     <= 1'b0;
      hit     <= 1'b0;
      evicted <= 1'b0;
      case (act_q)
        ACT_SET: begin
          if (job_nz) begin
            hit     <= found;
            evicted <= !found && !empty_found;
          end
        end
        ACT_CLEAR: begin
          hit <= job_nz && found;
        end
        ACT_QUERY: begin
          if (job_nz && found) begin
            hit <= 1'b1;
            due <= !wrap_before(now_q, found_dl);
          end else begin
            due <= 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

### hdl/retry_backoff_table.sv
`default_nettype none

// Retry deadline table with capped exponential backoff. Each item carries an
// action (set on failure, clear, query), a job id and the current tick count,
// and returns one result (due, hit, evicted). The table is read one entry per
// cycle through its single read port, then the tail state drains the read
// pipeline and the finish state writes the chosen slot and loads the result
// register. A new item is taken once the previous one has reached the result
// register. The table is empty after reset with no clearing pass. The user
// must write configuration only while no item is in flight; the block itself
// does not enforce it.
module retry_backoff_table #(
  parameter int ENTRIES = 8
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_we,
  input  wire logic [rbt_pkg::CFGI_W-1:0]   cfg_index,
  input  wire logic [rbt_pkg::CFGD_W-1:0]   cfg_data,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic [rbt_pkg::ACT_W-1:0]    action,
  input  wire logic [rbt_pkg::JOB_W-1:0]    job_id,
  input  wire logic [rbt_pkg::DBL_W-1:0]    retries,
  input  wire logic [rbt_pkg::TIME_W-1:0]   now_time,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic                              due,
  output logic                              hit,
  output logic                              evicted
);
  import rbt_pkg::*;

  rbt_cmd_t  cmd;
  rbt_stat_t stat;

  rbt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  rbt_datapath #(
    .ENTRIES (ENTRIES)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .action      (action),
    .job_id      (job_id),
    .retries     (retries),
    .now_time    (now_time),
    .due         (due),
    .hit         (hit),
    .evicted     (evicted)
  );

endmodule

`default_nettype wire
